/* hw/rtl/gam_pkg.sv */
// ----------------------------------------------------------------------------
// Gargle amplitude modulator package
// Shared widths, register indices and the envelope-to-lane gain type.
// ----------------------------------------------------------------------------
package gam_pkg;

	// Envelope gain is Q19.24: an 18-bit count times a 25-bit step.
	localparam int GAIN_FRAC = 24;
	localparam int CNT_W     = 18;
	localparam int STEP_W    = 25;
	localparam int GAIN_W    = CNT_W + STEP_W;
	localparam int GAIN_HI_W = GAIN_W - GAIN_FRAC;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = STEP_W;

	// Smallest period the counter honours; lower settings act as this.
	localparam logic [CNT_W-1:0] MIN_PERIOD = CNT_W'(2);

	// Register reset values.
	localparam logic [CNT_W-1:0]  PERIOD_RST = CNT_W'(2400);
	localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(13981);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD      = 2'd0,
		CFG_GAIN_STEP   = 2'd1,
		CFG_SQUARE_MODE = 2'd2
	} cfg_idx_t;

	// Gain split into integer and fractional parts for the lane multipliers.
	typedef struct packed {
		logic [GAIN_HI_W-1:0] hi;
		logic [GAIN_FRAC-1:0] lo;
	} gain_t;

endpackage

/* hw/rtl/gargle_amplitude_modulator.sv */
// ----------------------------------------------------------------------------
// Gargle amplitude modulator
// An accepted frame passes the stage-1, stage-2, lane product and output registers.
// Throughput: one stereo frame per cycle while the output is not stalled.
// Reset: arst_n clears the phase counter, the stage valid flags and restores
// period 2400, gain step 13981 and triangle mode; payload registers are not reset.
// ----------------------------------------------------------------------------
module gargle_amplitude_modulator import gam_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DAT_W-1:0]          cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] in_left,
	input  logic signed [SAMPLE_BITS-1:0] in_right,
	input  logic signed [SAMPLE_BITS-1:0] mix_left,
	input  logic signed [SAMPLE_BITS-1:0] mix_right,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right
);

	// Configuration registers.
	logic [CNT_W-1:0]  period_q;
	logic [STEP_W-1:0] gain_step_q;
	logic              square_mode_q;

	// The whole pipeline moves together; it holds only when a finished
	// result sits in the output register and the consumer is stalling.
	logic adv;
	logic fire;

	logic v_s1, v_s2, v_s3;
	logic signed [SAMPLE_BITS-1:0] left_s1, right_s1, mixl_s1, mixr_s1;
	logic signed [SAMPLE_BITS-1:0] left_s2, right_s2, mixl_s2, mixr_s2;
	gain_t gain_s2;
	logic signed [SAMPLE_BITS-1:0] res_left, res_right;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign fire     = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= PERIOD_RST;
			gain_step_q   <= STEP_RST;
			square_mode_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PERIOD:      period_q      <= cfg_data[CNT_W-1:0];
				CFG_GAIN_STEP:   gain_step_q   <= cfg_data;
				CFG_SQUARE_MODE: square_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Envelope: phase counter on acceptance, gain ready in the second stage.
	gam_envelope u_envelope (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.fire        (fire),
		.period      (period_q),
		.gain_step   (gain_step_q),
		.square_mode (square_mode_q),
		.gain_s2     (gain_s2)
	);

	// Transaction valid flags through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	// Sample and mix values wait alongside the envelope for the gain.
	always_ff @(posedge clk) begin
		if (adv) begin
			left_s1  <= in_left;
			right_s1 <= in_right;
			mixl_s1  <= mix_left;
			mixr_s1  <= mix_right;
			left_s2  <= left_s1;
			right_s2 <= right_s1;
			mixl_s2  <= mixl_s1;
			mixr_s2  <= mixr_s1;
		end
	end

	// One lane per channel, both driven by the same gain.
	gam_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
		.clk    (clk),
		.adv    (adv),
		.smp    (left_s2),
		.mix    (mixl_s2),
		.gain   (gain_s2),
		.result (res_left)
	);

	gam_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
		.clk    (clk),
		.adv    (adv),
		.smp    (right_s2),
		.mix    (mixr_s2),
		.gain   (gain_s2),
		.result (res_right)
	);

	// Merging stage: the two lane results form one output transaction.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_left  <= res_left;
			out_right <= res_right;
		end
	end

endmodule

/* hw/rtl/gam_envelope.sv */
// ----------------------------------------------------------------------------
// Gargle envelope generator
// Phase counter and triangle/square gain, registered over two stages.
// ----------------------------------------------------------------------------
module gam_envelope import gam_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              fire,
	input  logic [CNT_W-1:0]  period,
	input  logic [STEP_W-1:0] gain_step,
	input  logic              square_mode,
	output gain_t             gain_s2
);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  p_eff;
	logic [CNT_W-1:0]  cnt_cur;
	logic [CNT_W-1:0]  half;
	logic [CNT_W-1:0]  factor;
	logic [CNT_W:0]    cnt_inc;
	logic              below;

	logic [CNT_W-1:0]  factor_s1;
	logic [STEP_W-1:0] step_s1;
	logic              square_s1;
	logic              below_s1;

	always_comb begin
		p_eff   = (period < MIN_PERIOD) ? MIN_PERIOD : period;
		cnt_cur = (count_q >= p_eff) ? '0 : count_q;
		half    = p_eff >> 1;
		below   = cnt_cur < half;
		factor  = below ? cnt_cur : p_eff - cnt_cur;
		cnt_inc = {1'b0, cnt_cur} + (CNT_W+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= (cnt_inc >= {1'b0, p_eff}) ? '0 : cnt_inc[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			factor_s1 <= factor;
			step_s1   <= gain_step;
			square_s1 <= square_mode;
			below_s1  <= below;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (square_s1) begin
				gain_s2 <= below_s1 ? GAIN_W'(1) << GAIN_FRAC : '0;
			end else begin
				gain_s2 <= GAIN_W'(factor_s1) * GAIN_W'(step_s1);
			end
		end
	end

endmodule

/* hw/rtl/gam_lane.sv */
// ----------------------------------------------------------------------------
// Gargle modulation lane
// Scales one channel by the envelope gain and adds the mix value, saturated.
// ----------------------------------------------------------------------------
module gam_lane import gam_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	input  logic signed [SAMPLE_BITS-1:0] mix,
	input  gain_t                         gain,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int PH_W  = SAMPLE_BITS + GAIN_HI_W + 1;
	localparam int PL_W  = SAMPLE_BITS + GAIN_FRAC + 1;
	localparam int SUM_W = PH_W + 2;
	localparam logic signed [SUM_W-1:0] SMAX =
		SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

	logic signed [PH_W-1:0]  ph_s3;
	logic signed [PL_W-1:0]  pl_s3;
	logic signed [SAMPLE_BITS-1:0] mix_s3;
	logic signed [SUM_W-1:0] sum;

	// Partial products of the sample with the integer and fraction of the gain.
	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s3  <= PH_W'(smp * $signed({1'b0, gain.hi}));
			pl_s3  <= PL_W'(smp * $signed({1'b0, gain.lo}));
			mix_s3 <= mix;
		end
	end

	always_comb begin
		sum = SUM_W'(ph_s3) + SUM_W'(pl_s3 >>> GAIN_FRAC) + SUM_W'(mix_s3);
		if (sum > SMAX) begin
			result = SAMPLE_BITS'(SMAX);
		end else if (sum < SMIN) begin
			result = SAMPLE_BITS'(SMIN);
		end else begin
			result = SAMPLE_BITS'(sum);
		end
	end

endmodule
